// File: rtl/core/fwrc_pkg.sv
package fwrc_pkg;

    localparam int MSG_BYTES_DEF = 108;
    localparam int COUNT_W       = 9;
    localparam int COUNT_MAX     = (1 << COUNT_W) - 1;

    // words at this offset and beyond are neither checked nor captured
    localparam int CHECK_END     = 108;

    localparam int VSIZE_VALUE   = 60;
    localparam int ABI_MAJOR     = 3;

    // word offsets in the message
    localparam int OFF_HEADER    = 0;
    localparam int OFF_COMMAND   = 4;
    localparam int OFF_DSP_OFS   = 8;
    localparam int OFF_HOST_OFS  = 12;
    localparam int OFF_DSP_SIZE  = 16;
    localparam int OFF_HOST_SIZE = 20;
    localparam int OFF_VSIZE     = 24;
    localparam int OFF_VER_LO    = 28;
    localparam int OFF_VER_HI    = 32;
    localparam int OFF_ABI       = 64;
    localparam int OFF_HASH      = 68;
    localparam int OFF_RSVD0_LO  = 72;
    localparam int OFF_RSVD0_HI  = 84;
    localparam int OFF_FLAGS_LO  = 84;
    localparam int OFF_FLAGS_HI  = 88;
    localparam int OFF_RSVD1_LO  = 92;
    localparam int OFF_RSVD1_HI  = 108;

    localparam int ABI_LIMIT_W   = 12;
    localparam int CMD_W         = 32;
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_ABI_MINOR_LIMIT  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_EXPECTED_COMMAND = 2'd1;

    localparam logic [ABI_LIMIT_W-1:0] ABI_LIMIT_RESET = 12'hfff;
    localparam logic [CMD_W-1:0]       CMD_RESET       = 32'h7000_0000;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_SIZE  = 3'd1,
        ST_CMD   = 3'd2,
        ST_VSIZE = 3'd3,
        ST_ABI   = 3'd4,
        ST_RSVD  = 3'd5
    } status_t;

    typedef struct packed {
        logic [7:0] msg_byte;
        logic       final_byte;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] ver_major;
        logic [15:0] ver_minor;
        logic [15:0] ver_micro;
        logic [15:0] ver_build;
        logic [31:0] abi_word;
        logic [31:0] source_hash;
        logic [31:0] dsp_box_offset;
        logic [31:0] host_box_offset;
        logic [31:0] dsp_box_size;
        logic [31:0] host_box_size;
        logic [63:0] flag_bits;
    } out_item_t;

    // byte position at which the word at a given offset completes
    function automatic logic [COUNT_W-1:0] done_pos(input int off);
        return COUNT_W'(off + 3);
    endfunction

endpackage

// File: rtl/core/fwrc_word_check.sv
module fwrc_word_check #(
    parameter int MSG_BYTES = fwrc_pkg::MSG_BYTES_DEF
) (
    input  logic [fwrc_pkg::COUNT_W-1:0]     pos,
    input  logic [31:0]                      word,
    input  logic [fwrc_pkg::ABI_LIMIT_W-1:0] abi_minor_limit,
    input  logic [fwrc_pkg::CMD_W-1:0]       expected_command,
    output fwrc_pkg::status_t                err
);

    logic in_rsvd;

    always_comb begin
        in_rsvd = (pos >= fwrc_pkg::done_pos(fwrc_pkg::OFF_RSVD0_LO) &&
                   pos <  fwrc_pkg::done_pos(fwrc_pkg::OFF_RSVD0_HI)) ||
                  (pos >= fwrc_pkg::done_pos(fwrc_pkg::OFF_RSVD1_LO) &&
                   pos <  fwrc_pkg::done_pos(fwrc_pkg::OFF_RSVD1_HI));
        err = fwrc_pkg::ST_OK;
        if (pos == fwrc_pkg::done_pos(fwrc_pkg::OFF_HEADER)) begin
            if (word != 32'(MSG_BYTES)) err = fwrc_pkg::ST_SIZE;
        end else if (pos == fwrc_pkg::done_pos(fwrc_pkg::OFF_COMMAND)) begin
            if (word != expected_command) err = fwrc_pkg::ST_CMD;
        end else if (pos == fwrc_pkg::done_pos(fwrc_pkg::OFF_VSIZE)) begin
            if (word != 32'(fwrc_pkg::VSIZE_VALUE)) err = fwrc_pkg::ST_VSIZE;
        end else if (pos == fwrc_pkg::done_pos(fwrc_pkg::OFF_ABI)) begin
            if (word[31:24] != 8'(fwrc_pkg::ABI_MAJOR) || word[23:12] > abi_minor_limit)
                err = fwrc_pkg::ST_ABI;
        end else if (in_rsvd) begin
            if (word != 32'd0) err = fwrc_pkg::ST_RSVD;
        end
    end

endmodule

// File: rtl/core/fw_ready_message_checker_core.sv
// Firmware-ready message checker.
// s_ channel: one message byte per request, final_byte set on the last byte.
// m_ channel: one result per message, issued for the request that carries final_byte.
// cfg_ channel: register writes (index 0 ABI minor limit, index 1 expected command);
//   cfg_ready is always high, write only between messages.
// Bytes are assembled into little-endian words; each completed word is checked and
// the first failing check is held. Selected words are captured for the result.
// Throughput: one byte per cycle. Latency: the result is valid in the cycle after the
// final byte is accepted; the byte update and status resolve in one pass of logic
// between the message state registers and the result register.
// Stall: s_ready drops only while a result is held and m_ready is low, so bytes keep
// flowing as long as the result register is empty or being drained.
// Reset: synchronous active-low aresetn clears the byte count, the error code, the
// result valid and restores the configuration registers to their defaults.
// The byte count saturates at 511; a message of the wrong length reports a size error.
module fw_ready_message_checker_core #(
    parameter int MSG_BYTES = fwrc_pkg::MSG_BYTES_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  fwrc_pkg::in_item_t               s_item,
    output logic                             m_valid,
    input  logic                             m_ready,
    output fwrc_pkg::out_item_t              m_item,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [fwrc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [fwrc_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int CW = fwrc_pkg::COUNT_W;

    logic [fwrc_pkg::ABI_LIMIT_W-1:0] abi_limit_reg;
    logic [fwrc_pkg::CMD_W-1:0]       exp_cmd_reg;
    logic [CW-1:0]                    count_reg, count_next;
    logic [31:0]                      word_reg, word_next;
    fwrc_pkg::status_t                ferr_reg, ferr_next, word_err, st;
    logic [15:0]                      ver_reg [4];
    logic [31:0]                      cap_reg [8];
    logic                             m_valid_reg, m_valid_next;
    fwrc_pkg::out_item_t              m_item_reg, m_item_next;
    logic                             accept, word_done;

    assign cfg_ready = 1'b1;
    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_item    = m_item_reg;

    fwrc_word_check #(.MSG_BYTES(MSG_BYTES)) u_check (
        .pos              (count_reg),
        .word             (word_next),
        .abi_minor_limit  (abi_limit_reg),
        .expected_command (exp_cmd_reg),
        .err              (word_err)
    );

    always_comb begin
        word_next  = {s_item.msg_byte, word_reg[31:8]};
        word_done  = (count_reg[1:0] == 2'b11) && (count_reg < CW'(fwrc_pkg::CHECK_END));
        ferr_next  = (word_done && ferr_reg == fwrc_pkg::ST_OK) ? word_err : ferr_reg;
        count_next = (count_reg == CW'(fwrc_pkg::COUNT_MAX)) ? count_reg : count_reg + 1'b1;
        st         = (count_next != CW'(MSG_BYTES)) ? fwrc_pkg::ST_SIZE : ferr_next;

        // a new result loads while the old one drains, so valid stays up
        m_valid_next = (accept && s_item.final_byte) || (m_valid_reg && !m_ready);

        // an OK message is at least the checked length, so every capture is already done
        m_item_next = '0;
        m_item_next.status = st;
        if (st == fwrc_pkg::ST_OK) begin
            m_item_next.ver_major       = ver_reg[0];
            m_item_next.ver_minor       = ver_reg[1];
            m_item_next.ver_micro       = ver_reg[2];
            m_item_next.ver_build       = ver_reg[3];
            m_item_next.abi_word        = cap_reg[4];
            m_item_next.source_hash     = cap_reg[5];
            m_item_next.dsp_box_offset  = cap_reg[0];
            m_item_next.host_box_offset = cap_reg[1];
            m_item_next.dsp_box_size    = cap_reg[2];
            m_item_next.host_box_size   = cap_reg[3];
            m_item_next.flag_bits       = {cap_reg[7], cap_reg[6]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            abi_limit_reg <= fwrc_pkg::ABI_LIMIT_RESET;
            exp_cmd_reg   <= fwrc_pkg::CMD_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                fwrc_pkg::CFG_ABI_MINOR_LIMIT:
                    abi_limit_reg <= cfg_data[fwrc_pkg::ABI_LIMIT_W-1:0];
                fwrc_pkg::CFG_EXPECTED_COMMAND:
                    exp_cmd_reg   <= cfg_data[fwrc_pkg::CMD_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            word_reg    <= '0;
            ferr_reg    <= fwrc_pkg::ST_OK;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (accept) begin
                if (s_item.final_byte) begin
                    count_reg   <= '0;
                    word_reg    <= '0;
                    ferr_reg    <= fwrc_pkg::ST_OK;
                end else begin
                    count_reg <= count_next;
                    word_reg  <= word_next;
                    ferr_reg  <= ferr_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && s_item.final_byte) m_item_reg <= m_item_next;
        if (accept && word_done) begin
            case (count_reg)
                fwrc_pkg::done_pos(fwrc_pkg::OFF_DSP_OFS):   cap_reg[0] <= word_next;
                fwrc_pkg::done_pos(fwrc_pkg::OFF_HOST_OFS):  cap_reg[1] <= word_next;
                fwrc_pkg::done_pos(fwrc_pkg::OFF_DSP_SIZE):  cap_reg[2] <= word_next;
                fwrc_pkg::done_pos(fwrc_pkg::OFF_HOST_SIZE): cap_reg[3] <= word_next;
                fwrc_pkg::done_pos(fwrc_pkg::OFF_VER_LO): begin
                    ver_reg[0] <= word_next[15:0];
                    ver_reg[1] <= word_next[31:16];
                end
                fwrc_pkg::done_pos(fwrc_pkg::OFF_VER_HI): begin
                    ver_reg[2] <= word_next[15:0];
                    ver_reg[3] <= word_next[31:16];
                end
                fwrc_pkg::done_pos(fwrc_pkg::OFF_ABI):       cap_reg[4] <= word_next;
                fwrc_pkg::done_pos(fwrc_pkg::OFF_HASH):      cap_reg[5] <= word_next;
                fwrc_pkg::done_pos(fwrc_pkg::OFF_FLAGS_LO):  cap_reg[6] <= word_next;
                fwrc_pkg::done_pos(fwrc_pkg::OFF_FLAGS_HI):  cap_reg[7] <= word_next;
                default: ;
            endcase
        end
    end

endmodule

// File: bench/fw_ready_message_checker_core_tb.sv
`timescale 1ns / 1ps

module fw_ready_message_checker_core_tb;

    localparam int FRAME_MAX = 128;
    localparam int HOLD_CYCLES = 400;
    localparam logic [fwrc_pkg::CFG_INDEX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [fwrc_pkg::CFG_INDEX_W-1:0] CFG_SPARE_3 = 2'd3;

    typedef enum logic [4:0] {
        MK_GOOD, MK_GOOD_ZERO, MK_GOOD_ONES, MK_ABI_AT_LIMIT,
        MK_BAD_HEADER, MK_BAD_CMD, MK_BAD_VSIZE, MK_BAD_ABI_MAJOR, MK_ABI_OVER,
        MK_RSVD_A, MK_RSVD_B, MK_CMD_AND_RSVD,
        MK_SHORT, MK_ONE_BYTE, MK_LONG, MK_NOISE
    } msg_kind_t;

    // known = 1: status typed in by hand, every other field zero
    typedef struct packed {
        logic              known;
        fwrc_pkg::status_t st;
    } status_note_t;

    typedef struct packed {
        msg_kind_t         kind;
        logic              known;
        fwrc_pkg::status_t st;
    } frame_case_t;

    frame_case_t directed_cases [6] = '{
        '{MK_GOOD,         1'b0, fwrc_pkg::ST_OK},
        '{MK_CMD_AND_RSVD, 1'b1, fwrc_pkg::ST_CMD},
        '{MK_ONE_BYTE,     1'b1, fwrc_pkg::ST_SIZE},
        '{MK_SHORT,        1'b1, fwrc_pkg::ST_SIZE},
        '{MK_ONE_BYTE,     1'b1, fwrc_pkg::ST_SIZE},
        '{MK_SHORT,        1'b0, fwrc_pkg::ST_OK}
    };

    msg_kind_t broken_kinds [10] = '{
        MK_BAD_HEADER, MK_BAD_CMD, MK_BAD_VSIZE, MK_BAD_ABI_MAJOR, MK_ABI_OVER,
        MK_RSVD_A, MK_RSVD_B, MK_CMD_AND_RSVD, MK_LONG, MK_NOISE
    };

    int idle_send [4] = '{0, 55, 0, 19};
    int idle_recv [4] = '{0, 0, 55, 19};

    logic                             aclk;
    logic                             aresetn;
    logic                             s_valid;
    logic                             s_ready;
    fwrc_pkg::in_item_t               s_item;
    logic                             m_valid;
    logic                             m_ready;
    fwrc_pkg::out_item_t              m_item;
    logic                             cfg_valid;
    logic                             cfg_ready;
    logic [fwrc_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [fwrc_pkg::CFG_DATA_W-1:0]  cfg_data;

    fw_ready_message_checker_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // register copies, as the block should hold them
    logic [fwrc_pkg::ABI_LIMIT_W-1:0] abi_limit_q;
    logic [fwrc_pkg::CMD_W-1:0]       cmd_q;

    // message progress
    logic [fwrc_pkg::COUNT_W-1:0] seen_bytes;
    logic [31:0]                  word_acc;
    fwrc_pkg::status_t            first_fail;
    fwrc_pkg::out_item_t          caught;

    fwrc_pkg::out_item_t pending_results [$];
    status_note_t        status_notes [$];
    int                  fail_count = 0;

    logic [7:0] frame [FRAME_MAX];
    int         frame_len;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_req = 0;
    int hold_left = 0;

    initial aclk = 1'b0;
    always #6 aclk = ~aclk;

    initial begin
        #4_000_000;
        $display("Some tests failed");
        $finish;
    end

    function automatic fwrc_pkg::status_t word_verdict(int off, logic [31:0] w);
        if (off == fwrc_pkg::OFF_HEADER)
            return (w != fwrc_pkg::MSG_BYTES_DEF) ? fwrc_pkg::ST_SIZE : fwrc_pkg::ST_OK;
        if (off == fwrc_pkg::OFF_COMMAND)
            return (w != cmd_q) ? fwrc_pkg::ST_CMD : fwrc_pkg::ST_OK;
        if (off == fwrc_pkg::OFF_VSIZE)
            return (w != fwrc_pkg::VSIZE_VALUE) ? fwrc_pkg::ST_VSIZE : fwrc_pkg::ST_OK;
        if (off == fwrc_pkg::OFF_ABI)
            return (w[31:24] != fwrc_pkg::ABI_MAJOR || w[23:12] > abi_limit_q) ?
                fwrc_pkg::ST_ABI : fwrc_pkg::ST_OK;
        if ((off >= fwrc_pkg::OFF_RSVD0_LO && off < fwrc_pkg::OFF_RSVD0_HI) ||
            (off >= fwrc_pkg::OFF_RSVD1_LO && off < fwrc_pkg::OFF_RSVD1_HI))
            return (w != 0) ? fwrc_pkg::ST_RSVD : fwrc_pkg::ST_OK;
        return fwrc_pkg::ST_OK;
    endfunction

    task automatic clear_progress();
        seen_bytes = '0;
        word_acc = '0;
        first_fail = fwrc_pkg::ST_OK;
        caught = '0;
    endtask

    task automatic absorb_byte(fwrc_pkg::in_item_t it);
        int                  off;
        fwrc_pkg::status_t   verdict;
        fwrc_pkg::out_item_t res;
        status_note_t        note;
        word_acc = {it.msg_byte, word_acc[31:8]};
        if (seen_bytes[1:0] == 2'b11 && seen_bytes < fwrc_pkg::CHECK_END) begin
            off = int'(seen_bytes) - 3;
            verdict = word_verdict(off, word_acc);
            if (first_fail == fwrc_pkg::ST_OK) first_fail = verdict;
            case (off)
                fwrc_pkg::OFF_DSP_OFS:   caught.dsp_box_offset = word_acc;
                fwrc_pkg::OFF_HOST_OFS:  caught.host_box_offset = word_acc;
                fwrc_pkg::OFF_DSP_SIZE:  caught.dsp_box_size = word_acc;
                fwrc_pkg::OFF_HOST_SIZE: caught.host_box_size = word_acc;
                fwrc_pkg::OFF_VER_LO: begin
                    caught.ver_major = word_acc[15:0];
                    caught.ver_minor = word_acc[31:16];
                end
                fwrc_pkg::OFF_VER_HI: begin
                    caught.ver_micro = word_acc[15:0];
                    caught.ver_build = word_acc[31:16];
                end
                fwrc_pkg::OFF_ABI:       caught.abi_word = word_acc;
                fwrc_pkg::OFF_HASH:      caught.source_hash = word_acc;
                fwrc_pkg::OFF_FLAGS_LO:  caught.flag_bits[31:0] = word_acc;
                fwrc_pkg::OFF_FLAGS_HI:  caught.flag_bits[63:32] = word_acc;
                default: ;
            endcase
        end
        if (seen_bytes != fwrc_pkg::COUNT_MAX) seen_bytes = seen_bytes + 1'b1;
        if (it.final_byte) begin
            res = '0;
            res.status = (seen_bytes != fwrc_pkg::MSG_BYTES_DEF) ? fwrc_pkg::ST_SIZE : first_fail;
            if (res.status == fwrc_pkg::ST_OK) begin
                res = caught;
                res.status = fwrc_pkg::ST_OK;
            end
            if (status_notes.size() != 0) begin
                note = status_notes.pop_front();
                if (note.known) begin
                    res = '0;
                    res.status = note.st;
                end
            end
            pending_results.push_back(res);
            clear_progress();
        end
    endtask

    function automatic void match_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            fail_count++;
        end
    endfunction

    task automatic check_result(fwrc_pkg::out_item_t got);
        fwrc_pkg::out_item_t want;
        if (pending_results.size() == 0) begin
            $error("result with none pending, status %0d", got.status);
            fail_count++;
            return;
        end
        want = pending_results.pop_front();
        match_field("status", want.status, got.status);
        match_field("ver_major", want.ver_major, got.ver_major);
        match_field("ver_minor", want.ver_minor, got.ver_minor);
        match_field("ver_micro", want.ver_micro, got.ver_micro);
        match_field("ver_build", want.ver_build, got.ver_build);
        match_field("abi_word", want.abi_word, got.abi_word);
        match_field("source_hash", want.source_hash, got.source_hash);
        match_field("dsp_box_offset", want.dsp_box_offset, got.dsp_box_offset);
        match_field("host_box_offset", want.host_box_offset, got.host_box_offset);
        match_field("dsp_box_size", want.dsp_box_size, got.dsp_box_size);
        match_field("host_box_size", want.host_box_size, got.host_box_size);
        match_field("flag_bits", want.flag_bits, got.flag_bits);
    endtask

    always @(posedge aclk) begin
        if (aresetn !== 1'b1) begin
            abi_limit_q = fwrc_pkg::ABI_LIMIT_RESET;
            cmd_q = fwrc_pkg::CMD_RESET;
            clear_progress();
        end else begin
            if (m_valid && m_ready) check_result(m_item);
            if (s_valid && s_ready) absorb_byte(s_item);
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    fwrc_pkg::CFG_ABI_MINOR_LIMIT:
                        abi_limit_q = cfg_data[fwrc_pkg::ABI_LIMIT_W-1:0];
                    fwrc_pkg::CFG_EXPECTED_COMMAND:
                        cmd_q = cfg_data[fwrc_pkg::CMD_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req != 0) begin
                hold_left = hold_req;
                hold_req = 0;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    function automatic logic [31:0] nonzero_mask();
        return $urandom | (32'd1 << $urandom_range(31));
    endfunction

    function automatic void put_word(int off, logic [31:0] w);
        for (int k = 0; k < 4; k++) frame[off + k] = w[8*k +: 8];
    endfunction

    task automatic build_frame(msg_kind_t kind);
        logic [7:0]  fill;
        logic [31:0] w;
        frame_len = fwrc_pkg::MSG_BYTES_DEF;
        for (int i = 0; i < FRAME_MAX; i++) frame[i] = $urandom_range(255);
        if (kind == MK_GOOD_ZERO || kind == MK_GOOD_ONES) begin
            fill = (kind == MK_GOOD_ZERO) ? 8'h00 : 8'hff;
            for (int i = 0; i < fwrc_pkg::MSG_BYTES_DEF; i++) frame[i] = fill;
        end
        put_word(fwrc_pkg::OFF_HEADER, fwrc_pkg::MSG_BYTES_DEF);
        put_word(fwrc_pkg::OFF_COMMAND, cmd_q);
        put_word(fwrc_pkg::OFF_VSIZE, fwrc_pkg::VSIZE_VALUE);
        w = {8'(fwrc_pkg::ABI_MAJOR), 12'($urandom_range(abi_limit_q)), 12'($urandom)};
        if (kind == MK_GOOD_ZERO) w = {8'(fwrc_pkg::ABI_MAJOR), 24'd0};
        if (kind == MK_GOOD_ONES || kind == MK_ABI_AT_LIMIT)
            w = {8'(fwrc_pkg::ABI_MAJOR), abi_limit_q, 12'hfff};
        put_word(fwrc_pkg::OFF_ABI, w);
        for (int off = fwrc_pkg::OFF_RSVD0_LO; off < fwrc_pkg::OFF_RSVD0_HI; off += 4)
            put_word(off, 32'd0);
        for (int off = fwrc_pkg::OFF_RSVD1_LO; off < fwrc_pkg::OFF_RSVD1_HI; off += 4)
            put_word(off, 32'd0);
        case (kind)
            MK_BAD_HEADER:
                put_word(fwrc_pkg::OFF_HEADER, fwrc_pkg::MSG_BYTES_DEF ^ nonzero_mask());
            MK_BAD_CMD:    put_word(fwrc_pkg::OFF_COMMAND, cmd_q ^ nonzero_mask());
            MK_BAD_VSIZE:
                put_word(fwrc_pkg::OFF_VSIZE, fwrc_pkg::VSIZE_VALUE ^ nonzero_mask());
            MK_BAD_ABI_MAJOR: begin
                w[31:24] = 8'(fwrc_pkg::ABI_MAJOR) ^ 8'($urandom_range(255, 1));
                put_word(fwrc_pkg::OFF_ABI, w);
            end
            MK_ABI_OVER: begin
                // no minor can exceed the top limit, so break the major instead
                if (abi_limit_q != 12'hfff)
                    w[23:12] = 12'($urandom_range(4095, abi_limit_q + 1));
                else
                    w[31:24] = ~8'(fwrc_pkg::ABI_MAJOR);
                put_word(fwrc_pkg::OFF_ABI, w);
            end
            MK_RSVD_A:
                put_word(fwrc_pkg::OFF_RSVD0_LO + 4 * $urandom_range(2), nonzero_mask());
            MK_RSVD_B:
                put_word(fwrc_pkg::OFF_RSVD1_LO + 4 * $urandom_range(3), nonzero_mask());
            MK_CMD_AND_RSVD: begin
                put_word(fwrc_pkg::OFF_COMMAND, cmd_q ^ nonzero_mask());
                put_word(fwrc_pkg::OFF_RSVD1_LO + 4 * $urandom_range(3), nonzero_mask());
            end
            MK_SHORT:    frame_len = $urandom_range(6, 2);
            MK_ONE_BYTE: frame_len = 1;
            MK_LONG:     frame_len = $urandom_range(116, fwrc_pkg::MSG_BYTES_DEF + 1);
            MK_NOISE: begin
                frame_len = ($urandom_range(1) != 0) ? fwrc_pkg::MSG_BYTES_DEF :
                    $urandom_range(8, 1);
                for (int i = 0; i < FRAME_MAX; i++) frame[i] = $urandom_range(255);
            end
            default: ;
        endcase
    endtask

    task automatic send_byte(fwrc_pkg::in_item_t it);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_item <= it;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic send_frame(msg_kind_t kind, logic known, fwrc_pkg::status_t st);
        fwrc_pkg::in_item_t it;
        status_note_t       note;
        build_frame(kind);
        note.known = known;
        note.st = st;
        status_notes.push_back(note);
        for (int i = 0; i < frame_len; i++) begin
            it.msg_byte = frame[i];
            it.final_byte = (i == frame_len - 1);
            send_byte(it);
        end
    endtask

    task automatic write_reg(logic [fwrc_pkg::CFG_INDEX_W-1:0] idx,
                             logic [fwrc_pkg::CFG_DATA_W-1:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // drain all requests, then give the result register time to empty
    task automatic settle();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    function automatic msg_kind_t pick_kind();
        int r;
        r = $urandom_range(99);
        if (r < 55) return MK_GOOD;
        if (r < 60) return MK_ABI_AT_LIMIT;
        if (r < 63) return MK_GOOD_ONES;
        if (r < 66) return MK_GOOD_ZERO;
        return broken_kinds[$urandom_range(9)];
    endfunction

    function automatic msg_kind_t pick_short();
        return ($urandom_range(1) != 0) ? MK_ONE_BYTE : MK_SHORT;
    endfunction

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_item = '0;
        cfg_valid = 1'b0;
        cfg_index = fwrc_pkg::CFG_ABI_MINOR_LIMIT;
        cfg_data = '0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed frames at the reset register values
        foreach (directed_cases[i])
            send_frame(directed_cases[i].kind, directed_cases[i].known, directed_cases[i].st);

        for (int ph = 0; ph < 4; ph++) begin
            settle();
            case (ph)
                0: begin
                    write_reg(fwrc_pkg::CFG_ABI_MINOR_LIMIT, 32'd0);
                    write_reg(fwrc_pkg::CFG_EXPECTED_COMMAND, 32'd0);
                    // unused indexes must not disturb either register
                    write_reg(CFG_SPARE_2, $urandom);
                    write_reg(CFG_SPARE_3, $urandom);
                end
                1: begin
                    write_reg(fwrc_pkg::CFG_ABI_MINOR_LIMIT, 32'hffff_ffff);
                    write_reg(fwrc_pkg::CFG_EXPECTED_COMMAND, 32'hffff_ffff);
                end
                2: begin
                    write_reg(fwrc_pkg::CFG_ABI_MINOR_LIMIT, $urandom);
                    write_reg(fwrc_pkg::CFG_EXPECTED_COMMAND, $urandom);
                end
                default: begin
                    write_reg(fwrc_pkg::CFG_ABI_MINOR_LIMIT, $urandom_range(4095));
                    write_reg(fwrc_pkg::CFG_EXPECTED_COMMAND, fwrc_pkg::CMD_RESET);
                end
            endcase
            send_idle_pct = idle_send[ph];
            recv_stall_pct = idle_recv[ph];
            if (ph == 0 || ph == 2) send_frame(pick_kind(), 1'b0, fwrc_pkg::ST_OK);
            repeat (4) send_frame(pick_short(), 1'b0, fwrc_pkg::ST_OK);
        end

        // receiver holds off while short frames keep coming: input must stall
        settle();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_req = HOLD_CYCLES;
        repeat (8) send_frame(MK_ONE_BYTE, 1'b0, fwrc_pkg::ST_OK);
        repeat (2) send_frame(MK_SHORT, 1'b0, fwrc_pkg::ST_OK);

        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (8) @(posedge aclk);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
